FILE: hdl/tmn_pkg.sv
// Shared types and constants of the token mutex node.
package tmn_pkg;

  localparam int unsigned NODES_DEF      = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths of the stream payloads
  localparam int unsigned OP_W    = 2;
  localparam int unsigned NODE_W  = 3;
  localparam int unsigned VALUE_W = 16;

  // Configuration register map: word index taken from paddr[2]
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_NODE_ID = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_TOKEN   = 2'd2,
    OP_EXIT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_BCAST = 2'd0,
    ACT_GRANT = 2'd1,
    ACT_TOKEN = 2'd2
  } act_e;

  typedef struct packed {
    logic               last;
    logic [VALUE_W-1:0] value;
    logic [NODE_W-1:0]  slot;
    logic [NODE_W-1:0]  dest;
    act_e               action;
  } res_t;

endpackage

FILE: hdl/tmn_cram.sv
// Count table memory: one write port, one registered read port, per-entry valid bits.
module tmn_cram #(
  parameter  int unsigned DEPTH = 8,
  parameter  int unsigned WIDTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

  a_no_rw_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && re_i) |-> (waddr_i != raddr_i))
    else $error("read and write of the same entry in one cycle");

endmodule

FILE: hdl/tmn_seq.sv
// Event sequencer: flags, own counter, table read-modify-write, ring search, token send.
module tmn_seq #(
  parameter  int unsigned NODES      = tmn_pkg::NODES_DEF,
  parameter  int unsigned COUNT_BITS = tmn_pkg::COUNT_BITS_DEF,
  localparam int unsigned IW         = (NODES > 1) ? $clog2(NODES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_node_id_i,
  output logic [2:0]            node_id_o,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tmn_pkg::op_e          in_op_i,
  input  logic [2:0]            in_idx_i,
  input  logic [15:0]           in_val_i,
  input  logic                  in_last_i,
  output logic                  res_valid_o,
  output tmn_pkg::res_t         res_o,
  input  logic                  res_ready_i,
  output logic                  req_we_o,
  output logic [IW-1:0]         req_waddr_o,
  output logic [COUNT_BITS-1:0] req_wdata_o,
  output logic                  req_re_o,
  output logic [IW-1:0]         req_raddr_o,
  input  logic [COUNT_BITS-1:0] req_rdata_i,
  output logic                  srv_we_o,
  output logic [IW-1:0]         srv_waddr_o,
  output logic [COUNT_BITS-1:0] srv_wdata_o,
  output logic                  srv_re_o,
  output logic [IW-1:0]         srv_raddr_o,
  input  logic [COUNT_BITS-1:0] srv_rdata_i
);
  import tmn_pkg::*;

  localparam int unsigned CNT_W = $clog2(NODES + 1);
  localparam int unsigned CW    = COUNT_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REQ    = 5'b00010,
    S_RESP   = 5'b00100,
    S_SEARCH = 5'b01000,
    S_SEND   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [2:0]       node_id_q, node_id_d;
  logic             holding_q, holding_d;
  logic             inside_q, inside_d;
  logic [CW-1:0]    own_q, own_d;
  act_e             resp_act_q, resp_act_d;
  logic [IW-1:0]    op_idx_q, op_idx_d;
  logic [CW-1:0]    op_val_q, op_val_d;
  logic [IW-1:0]    scan_j_q, scan_j_d;
  logic [IW-1:0]    cand_q, cand_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [IW-1:0]    send_q, send_d;
  logic [IW-1:0]    dest_q, dest_d;

  logic          accept;
  logic [31:0]   idx_ext, val_ext, own_ext, srv_ext, dest_ext, send_ext;
  logic [IW-1:0] self_idx, first_j, next_j, idx_addr;
  logic          idx_ok;
  logic [CW-1:0] val_cnt, req_new;
  logic          hit, send_last;

  // Table index of this node: small constant lookup of node_id modulo NODES
  always_comb begin
    self_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (node_id_q == 3'(i)) begin
        self_idx = IW'(i % NODES);
      end
    end
  end

  assign first_j  = (self_idx == IW'(NODES - 1)) ? '0 : self_idx + 1'b1;
  assign next_j   = (scan_j_q == IW'(NODES - 1)) ? '0 : scan_j_q + 1'b1;

  assign idx_ext  = 32'(in_idx_i);
  assign idx_ok   = idx_ext < NODES;
  assign idx_addr = idx_ext[IW-1:0];
  assign val_ext  = 32'(in_val_i);
  assign val_cnt  = val_ext[CW-1:0];

  assign own_ext  = 32'(own_q);
  assign srv_ext  = 32'(srv_rdata_i);
  assign dest_ext = 32'(dest_q);
  assign send_ext = 32'(send_q);

  assign req_new   = (op_val_q > req_rdata_i) ? op_val_q : req_rdata_i;
  assign hit       = req_rdata_i > srv_rdata_i;
  assign send_last = send_q == IW'(NODES - 1);

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign node_id_o  = node_id_q;

  always_comb begin
    state_d    = state_q;
    node_id_d  = node_id_q;
    holding_d  = holding_q;
    inside_d   = inside_q;
    own_d      = own_q;
    resp_act_d = resp_act_q;
    op_idx_d   = op_idx_q;
    op_val_d   = op_val_q;
    scan_j_d   = scan_j_q;
    cand_d     = cand_q;
    cmp_vld_d  = cmp_vld_q;
    scan_cnt_d = scan_cnt_q;
    send_d     = send_q;
    dest_d     = dest_q;

    req_we_o    = 1'b0;
    req_waddr_o = op_idx_q;
    req_wdata_o = req_new;
    req_re_o    = 1'b0;
    req_raddr_o = scan_j_q;
    srv_we_o    = 1'b0;
    srv_waddr_o = idx_addr;
    srv_wdata_o = val_cnt;
    srv_re_o    = 1'b0;
    srv_raddr_o = scan_j_q;

    res_valid_o   = 1'b0;
    res_o.action  = resp_act_q;
    res_o.dest    = node_id_q;
    res_o.slot    = '0;
    res_o.value   = '0;
    res_o.last    = 1'b1;

    if (cfg_we_i) begin
      node_id_d = cfg_node_id_i;
      holding_d = cfg_node_id_i == 3'd0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_op_i)
            OP_ENTER: begin
              if (holding_q) begin
                inside_d   = 1'b1;
                resp_act_d = ACT_GRANT;
              end else begin
                if (own_q != '1) begin
                  own_d = own_q + 1'b1;
                end
                resp_act_d = ACT_BCAST;
              end
              state_d = S_RESP;
            end
            OP_REQUEST: begin
              if (idx_ok) begin
                req_re_o    = 1'b1;
                req_raddr_o = idx_addr;
                srv_re_o    = 1'b1;
                srv_raddr_o = idx_addr;
                op_idx_d    = idx_addr;
                op_val_d    = val_cnt;
                state_d     = S_REQ;
              end
            end
            OP_TOKEN: begin
              if (idx_ok) begin
                srv_we_o = 1'b1;
                if (in_last_i) begin
                  holding_d  = 1'b1;
                  inside_d   = 1'b1;
                  resp_act_d = ACT_GRANT;
                  state_d    = S_RESP;
                end
              end
            end
            OP_EXIT: begin
              if (inside_q) begin
                srv_we_o    = 1'b1;
                srv_waddr_o = self_idx;
                srv_wdata_o = own_q;
                inside_d    = 1'b0;
                if (holding_q) begin
                  scan_j_d   = first_j;
                  scan_cnt_d = '0;
                  cmp_vld_d  = 1'b0;
                  state_d    = S_SEARCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REQ: begin
        // Table data for the requester is back: merge and write it.
        req_we_o = 1'b1;
        if (holding_q && !inside_q && (req_new > srv_rdata_i)) begin
          scan_j_d   = first_j;
          scan_cnt_d = '0;
          cmp_vld_d  = 1'b0;
          state_d    = S_SEARCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        res_o.value = (resp_act_q == ACT_BCAST) ? own_ext[VALUE_W-1:0] : '0;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_SEARCH: begin
        // Issue one entry per cycle, compare the one read the cycle before.
        if (cmp_vld_q && hit) begin
          dest_d      = cand_q;
          holding_d   = 1'b0;
          srv_re_o    = 1'b1;
          srv_raddr_o = '0;
          send_d      = '0;
          cmp_vld_d   = 1'b0;
          state_d     = S_SEND;
        end else if (scan_cnt_q == CNT_W'(NODES)) begin
          cmp_vld_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          req_re_o   = 1'b1;
          srv_re_o   = 1'b1;
          cand_d     = scan_j_q;
          cmp_vld_d  = 1'b1;
          scan_cnt_d = scan_cnt_q + 1'b1;
          scan_j_d   = next_j;
        end
      end
      S_SEND: begin
        res_valid_o  = 1'b1;
        res_o.action = ACT_TOKEN;
        res_o.dest   = dest_ext[NODE_W-1:0];
        res_o.slot   = send_ext[NODE_W-1:0];
        res_o.value  = srv_ext[VALUE_W-1:0];
        res_o.last   = send_last;
        if (res_ready_i) begin
          if (send_last) begin
            state_d = S_IDLE;
          end else begin
            send_d      = send_q + 1'b1;
            srv_re_o    = 1'b1;
            srv_raddr_o = send_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      node_id_q  <= 3'd0;
      holding_q  <= 1'b1;
      inside_q   <= 1'b0;
      own_q      <= '0;
      resp_act_q <= ACT_GRANT;
      cmp_vld_q  <= 1'b0;
      scan_cnt_q <= '0;
      send_q     <= '0;
    end else begin
      state_q    <= state_d;
      node_id_q  <= node_id_d;
      holding_q  <= holding_d;
      inside_q   <= inside_d;
      own_q      <= own_d;
      resp_act_q <= resp_act_d;
      cmp_vld_q  <= cmp_vld_d;
      scan_cnt_q <= scan_cnt_d;
      send_q     <= send_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_idx_q <= op_idx_d;
    op_val_q <= op_val_d;
    scan_j_q <= scan_j_d;
    cand_q   <= cand_d;
    dest_q   <= dest_d;
  end

  a_req_after_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REQ) |-> ($past(state_q) == S_IDLE))
    else $error("table merge without a preceding request transfer");

  a_send_without_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND) |-> !holding_q)
    else $error("token words sent while the token flag is still set");

  a_search_data_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && scan_cnt_q != '0) |-> cmp_vld_q)
    else $error("search compare without read data");

  a_send_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND && res_ready_i && !send_last)
      |=> (state_q == S_SEND && send_q == IW'($past(send_q) + 1'b1)))
    else $error("token send skipped or repeated a slot");

endmodule

FILE: hdl/token_mutex_node.sv
// Top level of one token mutual-exclusion ring node: stream ports, register port, output stage.
//
// Usage:
//  - s_axis carries events: tuser holds the operation (enter, request message, token word,
//    exit), tdata holds node_index and count_value; tlast flags the final token word.
//  - m_axis carries results: tuser holds the action (broadcast request, entry grant,
//    outgoing token word); tlast marks the final result caused by one input transfer.
//  - The APB port holds node_id at address 0; writing it sets the token flag when the id
//    is 0 and clears it otherwise. Write it only while the node is idle.
//  - Flow: an enter or a final token word passes through the response state, which hands
//    the result to the output register that shows it on m_axis; an exit or another token
//    word is worked in the idle state; a request message reads both tables, then merges
//    and writes the request table. Passing the token adds a ring search, one table read
//    per cycle, and the token words, one table read per word the output register takes.
//  - One event is worked at a time; the next is taken as soon as the previous one has
//    handed its last result to the output register, or has finished if it owes none.
//  - Reset: node 0 holds the token, all counts and tables read as zero.
//  - A stalled m_axis holds the output register; the sequencer waits on it, and s_axis
//    stays ready only for events that are still to be started.
module token_mutex_node #(
  parameter int unsigned NODES      = tmn_pkg::NODES_DEF,
  parameter int unsigned COUNT_BITS = tmn_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmn_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Event input: tdata = node_index[2:0], count_value[18:3], zero[23:19]
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,
  // tuser = operation[1:0]
  input  logic [1:0]                  s_axis_tuser,
  input  logic                        s_axis_tlast,
  // Result output: tdata = dest_node[2:0], slot_index[5:3], out_value[21:6], zero[23:22]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,
  // tuser = action[1:0]
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);
  import tmn_pkg::*;

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [2:0]            node_id;
  logic                  cfg_we;
  logic                  res_valid, res_ready;
  res_t                  res;
  res_t                  out_q;
  logic                  out_vld_q;

  logic                  req_we, req_re, srv_we, srv_re;
  logic [IW-1:0]         req_waddr, req_raddr, srv_waddr, srv_raddr;
  logic [COUNT_BITS-1:0] req_wdata, req_rdata, srv_wdata, srv_rdata;

  // Register port: word index lives in paddr[2], no wait states.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NODE_ID);
  assign prdata = (paddr[2] == REG_NODE_ID) ? 32'(node_id) : '0;

  tmn_seq #(
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_node_id_i (pwdata[2:0]),
    .node_id_o     (node_id),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (op_e'(s_axis_tuser)),
    .in_idx_i      (s_axis_tdata[2:0]),
    .in_val_i      (s_axis_tdata[18:3]),
    .in_last_i     (s_axis_tlast),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .req_we_o      (req_we),
    .req_waddr_o   (req_waddr),
    .req_wdata_o   (req_wdata),
    .req_re_o      (req_re),
    .req_raddr_o   (req_raddr),
    .req_rdata_i   (req_rdata),
    .srv_we_o      (srv_we),
    .srv_waddr_o   (srv_waddr),
    .srv_wdata_o   (srv_wdata),
    .srv_re_o      (srv_re),
    .srv_raddr_o   (srv_raddr),
    .srv_rdata_i   (srv_rdata)
  );

  // Highest request number seen per node
  tmn_cram #(
    .DEPTH (NODES),
    .WIDTH (COUNT_BITS)
  ) u_req_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (req_we),
    .waddr_i (req_waddr),
    .wdata_i (req_wdata),
    .re_i    (req_re),
    .raddr_i (req_raddr),
    .rdata_o (req_rdata)
  );

  // Served counts carried by the token
  tmn_cram #(
    .DEPTH (NODES),
    .WIDTH (COUNT_BITS)
  ) u_srv_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (srv_we),
    .waddr_i (srv_waddr),
    .wdata_i (srv_wdata),
    .re_i    (srv_re),
    .raddr_i (srv_raddr),
    .rdata_o (srv_rdata)
  );

  // Output register: take a new result when empty or when the current one transfers.
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.value, out_q.slot, out_q.dest};
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: verif/tb_token_mutex_node.sv
// Self-checking testbench of the token mutex node: stream stimulus, APB setup, result checker.
`timescale 1ns / 1ps

module tb_token_mutex_node;
  import tmn_pkg::*;

  localparam int unsigned NODES      = NODES_DEF;
  localparam int unsigned COUNT_BITS = COUNT_BITS_DEF;
  // Cycles to let a no-result event (ring search included) run out before a register write
  localparam int unsigned SETTLE     = 2 * NODES + 16;

  // One event as it travels on s_axis
  typedef struct {
    op_e                op;
    logic [NODE_W-1:0]  peer;
    logic [VALUE_W-1:0] count;
    logic               fin;
  } node_event_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // node_index[2:0], count_value[18:3], zero[23:19]
  logic [23:0]          s_axis_tdata  = '0;
  // operation[1:0]
  logic [1:0]           s_axis_tuser  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // dest_node[2:0], slot_index[5:3], out_value[21:6], zero[23:22]
  logic [23:0]          m_axis_tdata;
  // action[1:0]
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  token_mutex_node #(
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Events waiting to be offered, and results the node still owes
  node_event_t event_q[$];
  res_t        outcome_q[$];

  // Shadow of the node: ring position, token and section flags, counters and tables
  logic [NODE_W-1:0]  ring_id;
  logic               holds_token;
  logic               in_section;
  logic [VALUE_W-1:0] own_ticket;
  logic [VALUE_W-1:0] req_high   [NODES];
  logic [VALUE_W-1:0] served_cnt [NODES];

  // Stimulus-side guess of each peer's latest request number
  logic [VALUE_W-1:0] peer_req [NODES];

  int unsigned src_idle_pct  = 16;
  int unsigned sink_idle_pct = 84;
  logic        sink_hold     = 1'b0;
  logic        stress_go     = 1'b0;
  logic        ev_taken      = 1'b0;
  int unsigned err_count     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count a mismatch and print it on one line
  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic push_outcome(input act_e act, input logic [NODE_W-1:0] dest,
                              input logic [NODE_W-1:0] slot, input logic [VALUE_W-1:0] val,
                              input logic fin);
    res_t r;
    r.action = act;
    r.dest   = dest;
    r.slot   = slot;
    r.value  = val;
    r.last   = fin;
    outcome_q.push_back(r);
  endtask

  // Search the ring after this node for the first pending peer; if one is found,
  // drop the token and owe one token word per slot, slot 0 first.
  task automatic hand_off_token();
    int  k;
    int  j;
    int  dest;
    bit  found;
    found = 1'b0;
    dest  = 0;
    for (k = 1; k <= NODES; k++) begin
      j = (int'(ring_id) + k) % NODES;
      if (!found && req_high[j] > served_cnt[j]) begin
        found = 1'b1;
        dest  = j;
      end
    end
    if (found) begin
      holds_token = 1'b0;
      for (k = 0; k < NODES; k++)
        push_outcome(ACT_TOKEN, NODE_W'(dest), NODE_W'(k), served_cnt[k], k == NODES - 1);
    end
  endtask

  // Advance the shadow by one accepted event and queue what it must produce
  task automatic node_apply(input op_e op, input logic [NODE_W-1:0] peer,
                            input logic [VALUE_W-1:0] count, input logic fin);
    case (op)
      OP_ENTER: begin
        if (holds_token) begin
          in_section = 1'b1;
          push_outcome(ACT_GRANT, ring_id, '0, '0, 1'b1);
        end else begin
          if (own_ticket != '1) own_ticket++;
          push_outcome(ACT_BCAST, ring_id, '0, own_ticket, 1'b1);
        end
      end
      OP_REQUEST: begin
        if (count > req_high[peer]) req_high[peer] = count;
        if (holds_token && !in_section && req_high[peer] > served_cnt[peer])
          hand_off_token();
      end
      OP_TOKEN: begin
        served_cnt[peer] = count;
        if (fin) begin
          holds_token = 1'b1;
          in_section  = 1'b1;
          push_outcome(ACT_GRANT, ring_id, '0, '0, 1'b1);
        end
      end
      default: begin
        // exit outside the section is ignored
        if (in_section) begin
          served_cnt[ring_id % NODES] = own_ticket;
          in_section = 1'b0;
          if (holds_token) hand_off_token();
        end
      end
    endcase
  endtask

  // Driver: hold the offered event until it transfers, then offer the next or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || ev_taken) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, event_q[0].count, event_q[0].peer};
        s_axis_tuser  <= event_q[0].op;
        s_axis_tlast  <= event_q[0].fin;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus the long hold-off while sink_hold is up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Monitor: check each result transfer first, then fold the accepted event into the
  // shadow, so a result never meets expectations of the event taken on the same edge.
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    ev_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action = act_e'(m_axis_tuser);
      got.dest   = m_axis_tdata[2:0];
      got.slot   = m_axis_tdata[5:3];
      got.value  = m_axis_tdata[21:6];
      got.last   = m_axis_tlast;
      if (outcome_q.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing expected", got));
      end else begin
        want = outcome_q.pop_front();
        if (got.action !== want.action)
          flag_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
        if (got.dest !== want.dest)
          flag_mismatch($sformatf("dest_node %0d, want %0d", got.dest, want.dest));
        if (got.slot !== want.slot)
          flag_mismatch($sformatf("slot_index %0d, want %0d", got.slot, want.slot));
        if (got.value !== want.value)
          flag_mismatch($sformatf("out_value %h, want %h", got.value, want.value));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      node_apply(op_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[18:3],
                 s_axis_tlast);
      void'(event_q.pop_front());
    end
  end

  task automatic push_event(input op_e op, input logic [NODE_W-1:0] peer,
                            input logic [VALUE_W-1:0] count, input logic fin);
    node_event_t ev;
    ev.op    = op;
    ev.peer  = peer;
    ev.count = count;
    ev.fin   = fin;
    event_q.push_back(ev);
  endtask

  // A whole token: one word per slot, the final one flagged
  task automatic push_token_train();
    int                 i;
    logic [VALUE_W-1:0] v;
    for (i = 0; i < NODES; i++) begin
      v = peer_req[i];
      // leave some peers one request behind so the next hand-off has a target
      if (v != '0 && $urandom_range(0, 1) == 1) v--;
      push_event(OP_TOKEN, NODE_W'(i), v, i == NODES - 1);
    end
  endtask

  // Mostly well-formed traffic: wishes, exits, fresh peer requests and whole tokens;
  // the rest is stale requests, torn tokens and random noise.
  task automatic push_random_events(input int n);
    int                 made;
    int                 pick;
    int                 p;
    int                 k;
    logic [VALUE_W-1:0] v;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        push_event(OP_ENTER, NODE_W'($urandom), VALUE_W'($urandom), 1'($urandom));
        made++;
      end else if (pick < 46) begin
        push_event(OP_EXIT, NODE_W'($urandom), VALUE_W'($urandom), 1'($urandom));
        made++;
      end else if (pick < 74) begin
        p = $urandom_range(0, NODES - 1);
        k = $urandom_range(0, 9);
        if (k < 7) begin
          if (peer_req[p] != '1) peer_req[p]++;
          v = peer_req[p];
        end else if (k < 9) begin
          v = VALUE_W'($urandom_range(0, peer_req[p]));
        end else begin
          v = VALUE_W'($urandom);
        end
        push_event(OP_REQUEST, NODE_W'(p), v, 1'($urandom));
        made++;
      end else if (pick < 92) begin
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, 3);
          repeat (k)
            push_event(OP_TOKEN, NODE_W'($urandom), VALUE_W'($urandom), 1'($urandom));
          made += k;
        end else begin
          push_token_train();
          made += NODES;
        end
      end else begin
        push_event(op_e'($urandom_range(0, 3)), NODE_W'($urandom), VALUE_W'($urandom),
                   1'($urandom));
        made++;
      end
    end
  endtask

  // Register write: setup then access; the node takes it on the edge with pready high
  task automatic write_node_id(input logic [NODE_W-1:0] id);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NODE_ID, 2'b00};
    pwdata  <= 32'(id);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ring_id     = id;
    holds_token = (id == '0);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every event has transferred and every owed result has come, then let
  // any silent event finish its search
  task automatic wait_quiet();
    do @(negedge clk_i); while (event_q.size() != 0 || outcome_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Hold the receiver off for a long stretch while events keep coming, so the node
  // backs up into its input
  initial begin : hold_off
    wait (stress_go);
    repeat (40) @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    ring_id     = '0;
    holds_token = 1'b1;
    in_section  = 1'b0;
    own_ticket  = '0;
    for (i = 0; i < NODES; i++) begin
      req_high[i]   = '0;
      served_cnt[i] = '0;
      peer_req[i]   = '0;
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: node 0 with the token, sender idles a little, receiver a lot
    write_node_id(3'd0);
    // grant with the token, also a second time while already inside
    push_event(OP_ENTER, 3'd0, 16'h0000, 1'b0);
    push_event(OP_ENTER, 3'd7, 16'hFFFF, 1'b1);
    // a request while inside must not move the token
    push_event(OP_REQUEST, 3'd5, 16'h0001, 1'b0);
    // exit hands the token to node 5
    push_event(OP_EXIT, 3'd0, 16'h0000, 1'b0);
    // no token: two broadcasts, the second while already pending
    push_event(OP_ENTER, 3'd0, 16'h0000, 1'b0);
    push_event(OP_ENTER, 3'd0, 16'h0000, 1'b0);
    // request at full scale, then a lower one that must not lower the table
    push_event(OP_REQUEST, 3'd2, 16'hFFFF, 1'b0);
    push_event(OP_REQUEST, 3'd2, 16'h0003, 1'b1);
    // whole token back: grant on the final word
    push_event(OP_TOKEN, 3'd0, 16'h0002, 1'b0);
    push_event(OP_TOKEN, 3'd1, 16'hFFFF, 1'b0);
    push_event(OP_TOKEN, 3'd2, 16'h0000, 1'b0);
    push_event(OP_TOKEN, 3'd3, 16'h0000, 1'b0);
    push_event(OP_TOKEN, 3'd4, 16'h0000, 1'b0);
    push_event(OP_TOKEN, 3'd5, 16'h0001, 1'b0);
    push_event(OP_TOKEN, 3'd6, 16'h0000, 1'b0);
    push_event(OP_TOKEN, 3'd7, 16'h0000, 1'b1);
    // exit passes over node 1 (served above request) to node 2
    push_event(OP_EXIT, 3'd0, 16'h0000, 1'b0);
    // exit outside the section is dropped
    push_event(OP_EXIT, 3'd0, 16'h0000, 1'b0);
    // a request under our own index, then a one-word token that still grants
    push_event(OP_REQUEST, 3'd0, 16'h0005, 1'b0);
    push_event(OP_TOKEN, 3'd4, 16'h8000, 1'b1);
    push_event(OP_TOKEN, 3'd2, 16'hFFFF, 1'b0);
    // nobody else pending: the search wraps and lands on this node
    push_event(OP_EXIT, 3'd0, 16'h0000, 1'b0);
    push_random_events(80);
    wait_quiet();

    // Phase 2: highest id, sender idles a lot, receiver a little
    src_idle_pct  <= 84;
    sink_idle_pct <= 16;
    write_node_id(3'd7);
    push_token_train();
    push_random_events(80);
    wait_quiet();

    // Phase 3: no idling, with the long receiver hold-off
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    write_node_id(3'd3);
    stress_go <= 1'b1;
    push_random_events(80);
    wait_quiet();

    // Phase 4: without the token, a few broadcasts, then take a token and exit so the
    // own count lands in the served table
    write_node_id(3'd5);
    repeat (4) push_event(OP_ENTER, 3'd0, 16'h0000, 1'b0);
    push_token_train();
    push_event(OP_EXIT, 3'd0, 16'h0000, 1'b0);
    push_random_events(30);
    wait_quiet();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: token_mutex_node.f
hdl/tmn_pkg.sv
hdl/tmn_cram.sv
hdl/tmn_seq.sv
hdl/token_mutex_node.sv
verif/tb_token_mutex_node.sv
